// File: sv/renc_pkg.sv
// ----------------------------------------------------------------------------
// Roman numeral encoder package
// Shared types, constants and letter tables of the Roman numeral encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package renc_pkg;

    localparam int unsigned IN_W      = 16;
    localparam int unsigned THOU_W    = 7;
    localparam int unsigned DIGIT_W   = 4;
    localparam int unsigned CODE_W    = 7;
    localparam int unsigned OUT_DATA_W = 8;

    // Upper bound on the letters of one numeral; the run is cut there.
    localparam int unsigned MAX_RESULTS = 51;
    localparam int unsigned CNT_W       = $clog2(MAX_RESULTS);

    // Depth of the queue between the digit splitter and the letter sequencer.
    localparam int unsigned QUEUE_DEPTH = 2;

    // Reciprocal of 1000 scaled by 2^22, rounded down so that the quotient
    // estimate is either exact or one too small.
    localparam logic [12:0] RECIP_1000 = 13'd4194;
    localparam int unsigned RECIP_1000_SHIFT = 22;

    // ASCII codes of the letters.
    localparam logic [CODE_W-1:0] CH_I = 7'h49;
    localparam logic [CODE_W-1:0] CH_V = 7'h56;
    localparam logic [CODE_W-1:0] CH_X = 7'h58;
    localparam logic [CODE_W-1:0] CH_L = 7'h4C;
    localparam logic [CODE_W-1:0] CH_C = 7'h43;
    localparam logic [CODE_W-1:0] CH_D = 7'h44;
    localparam logic [CODE_W-1:0] CH_M = 7'h4D;

    // Places of a number, in emission order.
    typedef enum logic [1:0] {
        PL_THOU = 2'd0,
        PL_HUND = 2'd1,
        PL_TENS = 2'd2,
        PL_ONES = 2'd3
    } place_t;

    // Role of a letter inside one digit's pattern.
    typedef enum logic [1:0] {
        SYM_UNIT = 2'd0,
        SYM_FIVE = 2'd1,
        SYM_NEXT = 2'd2
    } sym_t;

    // A number split into its decimal places.
    typedef struct packed {
        logic [THOU_W-1:0]  thou;
        logic [DIGIT_W-1:0] hund;
        logic [DIGIT_W-1:0] tens;
        logic [DIGIT_W-1:0] ones;
    } digits_t;

    // Number of letters that one decimal digit produces.
    function automatic logic [2:0] pat_len(input logic [DIGIT_W-1:0] d);
        logic [2:0] len;
        begin
            case (d)
                4'd1:    len = 3'd1;
                4'd2:    len = 3'd2;
                4'd3:    len = 3'd3;
                4'd4:    len = 3'd2;
                4'd5:    len = 3'd1;
                4'd6:    len = 3'd2;
                4'd7:    len = 3'd3;
                4'd8:    len = 3'd4;
                4'd9:    len = 3'd2;
                default: len = 3'd0;
            endcase
            return len;
        end
    endfunction

    // Role of letter k within the pattern of digit d.
    function automatic sym_t pat_sym(input logic [DIGIT_W-1:0] d, input logic [1:0] k);
        sym_t s;
        begin
            case (d)
                4'd4:                s = (k == 2'd1) ? SYM_FIVE : SYM_UNIT;
                4'd5, 4'd6, 4'd7, 4'd8: s = (k == 2'd0) ? SYM_FIVE : SYM_UNIT;
                4'd9:                s = (k == 2'd1) ? SYM_NEXT : SYM_UNIT;
                default:             s = SYM_UNIT;
            endcase
            return s;
        end
    endfunction

    // Letter for a role at a place.
    function automatic logic [CODE_W-1:0] place_letter(input place_t p, input sym_t s);
        logic [CODE_W-1:0] c;
        begin
            case (p)
                PL_HUND: c = (s == SYM_UNIT) ? CH_C : ((s == SYM_FIVE) ? CH_D : CH_M);
                PL_TENS: c = (s == SYM_UNIT) ? CH_X : ((s == SYM_FIVE) ? CH_L : CH_C);
                PL_ONES: c = (s == SYM_UNIT) ? CH_I : ((s == SYM_FIVE) ? CH_V : CH_X);
                default: c = CH_M;
            endcase
            return c;
        end
    endfunction

endpackage

`default_nettype wire

// File: sv/roman_numeral_encoder_top.sv
// ----------------------------------------------------------------------------
// Roman numeral encoder
// Converts whole numbers into Roman numerals, one ASCII letter per transfer.
// ----------------------------------------------------------------------------
// Usage:
// A number enters on the s_ channel in s_tdata[15:0]; values above MAX_VALUE
// are taken as MAX_VALUE. Its numeral leaves on the m_ channel, one letter per
// transfer in m_tdata[6:0], with m_tlast high on the final letter. Thousands
// are repeated M. A zero produces no transfer at all. At most 51 letters are
// sent for one number; a longer numeral is cut there, the last one sent
// carrying m_tlast.
// The front end takes a new number only once it has pushed the last one and
// splits it into digits with one constant multiply per cycle, then passes it
// through a two-entry queue. The letter sequencer first loads a number and
// then sends one letter per cycle while m_tready does not stall it; it takes
// the next number only once the last letter is sent.
// The first letter passes the splitter, the queue and the output register.
// While the sequencer works, the front end already splits the next numbers.
// A stall on m_tready holds the output register and the sequencer; the queue
// then fills and s_tready drops. Reset empties the queue and all stages.
// ----------------------------------------------------------------------------
`default_nettype none

module roman_numeral_encoder_top #(
    parameter int unsigned MAX_VALUE = 40000
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [renc_pkg::IN_W-1:0]        s_tdata,   // [15:0] number_value
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [renc_pkg::OUT_DATA_W-1:0]       m_tdata,   // [6:0] letter_code, [7] zero
    output logic                                  m_tlast    // last_letter
);

    logic                           push_valid;
    logic                           push_ready;
    renc_pkg::digits_t              push_data;
    logic                           pop_valid;
    logic                           pop_ready;
    renc_pkg::digits_t              pop_data;
    logic [renc_pkg::CODE_W-1:0]    letter_code;

    renc_front #(
        .MAX_VALUE (MAX_VALUE)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    renc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_data   (push_data),
        .out_valid (pop_valid),
        .out_ready (pop_ready),
        .out_data  (pop_data)
    );

    renc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (pop_valid),
        .in_ready (pop_ready),
        .in_data  (pop_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_code   (letter_code),
        .m_last   (m_tlast)
    );

    assign m_tdata = {1'b0, letter_code};

endmodule

`default_nettype wire

// File: sv/renc_front.sv
// ----------------------------------------------------------------------------
// Roman numeral encoder front end
// Accepts a number, saturates it and splits it into thousands, hundreds,
// tens and ones with one constant multiply per cycle, then queues the digits.
// ----------------------------------------------------------------------------
`default_nettype none

module renc_front #(
    parameter int unsigned MAX_VALUE = 40000
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [renc_pkg::IN_W-1:0]     s_tdata,
    output logic                               push_valid,
    input  wire logic                          push_ready,
    output renc_pkg::digits_t                  push_data
);

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_QEST = 8'b0000_0010,
        ST_QFIX = 8'b0000_0100,
        ST_HUND = 8'b0000_1000,
        ST_LOW  = 8'b0001_0000,
        ST_TENS = 8'b0010_0000,
        ST_ONES = 8'b0100_0000,
        ST_PUSH = 8'b1000_0000
    } front_state_t;

    front_state_t                       state_reg, state_next;
    logic [renc_pkg::IN_W-1:0]          val_reg, val_next;
    logic [renc_pkg::THOU_W-1:0]        thou_reg, thou_next;
    logic [9:0]                         rem_reg, rem_next;
    logic [renc_pkg::DIGIT_W-1:0]       hund_reg, hund_next;
    logic [6:0]                         low_reg, low_next;
    logic [renc_pkg::DIGIT_W-1:0]       tens_reg, tens_next;
    logic [renc_pkg::DIGIT_W-1:0]       ones_reg, ones_next;

    logic [renc_pkg::IN_W-1:0]          sat_value;
    logic [28:0]                        qest_prod;
    logic [16:0]                        thou_scaled;
    logic [16:0]                        diff_full;
    logic [10:0]                        diff_low;
    logic [15:0]                        hund_prod;
    logic [10:0]                        hund_scaled;
    logic [9:0]                         low_full;
    logic [14:0]                        tens_prod;
    logic [7:0]                         tens_scaled;
    logic [6:0]                         ones_full;

    assign sat_value = (s_tdata > renc_pkg::IN_W'(MAX_VALUE))
                       ? renc_pkg::IN_W'(MAX_VALUE) : s_tdata;

    assign qest_prod   = 29'(val_reg) * 29'(renc_pkg::RECIP_1000);
    assign thou_scaled = 17'(thou_reg) * 17'd1000;
    assign diff_full   = 17'(val_reg) - thou_scaled;
    // The estimate is at most one too small, so the remainder is below 2000.
    assign diff_low    = diff_full[10:0];
    assign hund_prod   = 16'(rem_reg) * 16'd41;
    assign hund_scaled = 11'(hund_reg) * 11'd100;
    assign low_full    = rem_reg - 10'(hund_scaled);
    assign tens_prod   = 15'(low_reg) * 15'd205;
    assign tens_scaled = 8'(tens_reg) * 8'd10;
    assign ones_full   = low_reg - 7'(tens_scaled);

    assign s_tready   = (state_reg == ST_IDLE);
    assign push_valid = (state_reg == ST_PUSH);
    assign push_data  = '{thou: thou_reg, hund: hund_reg, tens: tens_reg, ones: ones_reg};

    always_comb begin
        state_next = state_reg;
        val_next   = val_reg;
        thou_next  = thou_reg;
        rem_next   = rem_reg;
        hund_next  = hund_reg;
        low_next   = low_reg;
        tens_next  = tens_reg;
        ones_next  = ones_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    val_next   = sat_value;
                    state_next = ST_QEST;
                end
            end
            ST_QEST: begin
                thou_next  = qest_prod[28:renc_pkg::RECIP_1000_SHIFT];
                state_next = ST_QFIX;
            end
            ST_QFIX: begin
                if (diff_low >= 11'd1000) begin
                    thou_next = thou_reg + 1'b1;
                    rem_next  = 10'(diff_low - 11'd1000);
                end else begin
                    rem_next  = diff_low[9:0];
                end
                state_next = ST_HUND;
            end
            ST_HUND: begin
                hund_next  = hund_prod[15:12];
                state_next = ST_LOW;
            end
            ST_LOW: begin
                low_next   = low_full[6:0];
                state_next = ST_TENS;
            end
            ST_TENS: begin
                tens_next  = tens_prod[14:11];
                state_next = ST_ONES;
            end
            ST_ONES: begin
                ones_next  = ones_full[3:0];
                state_next = ST_PUSH;
            end
            ST_PUSH: begin
                if (push_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg  <= val_next;
        thou_reg <= thou_next;
        rem_reg  <= rem_next;
        hund_reg <= hund_next;
        low_reg  <= low_next;
        tens_reg <= tens_next;
        ones_reg <= ones_next;
    end

endmodule

`default_nettype wire

// File: sv/renc_queue.sv
// ----------------------------------------------------------------------------
// Roman numeral encoder digit queue
// A short first-in first-out queue of split numbers between the front end
// and the letter sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module renc_queue (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire renc_pkg::digits_t   in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output renc_pkg::digits_t        out_data
);

    localparam int unsigned DEPTH = renc_pkg::QUEUE_DEPTH;
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    renc_pkg::digits_t  mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_write;
    logic               do_read;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign do_write  = in_valid && in_ready;
    assign do_read   = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_write) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_read) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_write && !do_read) begin
            count_next = count_reg + 1'b1;
        end else if (do_read && !do_write) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_write) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

`default_nettype wire

// File: sv/renc_back.sv
// ----------------------------------------------------------------------------
// Roman numeral encoder letter sequencer
// Takes one split number from the queue and emits its letters, one per cycle
// unless m_tready stalls, via an output register, flagging the final letter.
// ----------------------------------------------------------------------------
`default_nettype none

module renc_back (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire renc_pkg::digits_t                in_data,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [renc_pkg::CODE_W-1:0]           m_code,
    output logic                                  m_last
);

    logic                           busy_reg, busy_next;
    renc_pkg::digits_t              rec_reg, rec_next;
    logic [3:0]                     mask_reg, mask_next;
    logic [1:0]                     pos_reg, pos_next;
    logic [renc_pkg::CNT_W-1:0]     sent_reg, sent_next;
    logic                           out_valid_reg, out_valid_next;
    logic [renc_pkg::CODE_W-1:0]    out_code_reg, out_code_next;
    logic                           out_last_reg, out_last_next;

    renc_pkg::place_t               place;
    logic [renc_pkg::DIGIT_W-1:0]   digit;
    logic [renc_pkg::CODE_W-1:0]    letter;
    logic                           place_done;
    logic [3:0]                     place_bit;
    logic [3:0]                     mask_after;
    logic                           is_last;
    logic                           emit;
    logic                           load;
    logic [3:0]                     load_mask;

    // Bit 0 of the mask stands for the thousands, bits 1 to 3 for the digits.
    always_comb begin
        if (mask_reg[0]) begin
            place = renc_pkg::PL_THOU;
        end else if (mask_reg[1]) begin
            place = renc_pkg::PL_HUND;
        end else if (mask_reg[2]) begin
            place = renc_pkg::PL_TENS;
        end else begin
            place = renc_pkg::PL_ONES;
        end
    end

    always_comb begin
        case (place)
            renc_pkg::PL_HUND: digit = rec_reg.hund;
            renc_pkg::PL_TENS: digit = rec_reg.tens;
            renc_pkg::PL_ONES: digit = rec_reg.ones;
            default:           digit = '0;
        endcase
    end

    assign letter = renc_pkg::place_letter(place, renc_pkg::pat_sym(digit, pos_reg));
    assign place_done = (place == renc_pkg::PL_THOU)
                        ? (rec_reg.thou == renc_pkg::THOU_W'(1))
                        : (3'(pos_reg) + 3'd1 == renc_pkg::pat_len(digit));
    assign place_bit  = 4'b0001 << place;
    assign mask_after = place_done ? (mask_reg & ~place_bit) : mask_reg;
    assign is_last    = (mask_after == 4'b0000)
                        || (sent_reg == renc_pkg::CNT_W'(renc_pkg::MAX_RESULTS - 1));

    assign emit     = busy_reg && (!out_valid_reg || m_tready);
    assign in_ready = !busy_reg;
    assign load     = in_valid && !busy_reg;

    assign load_mask = {in_data.ones != '0, in_data.tens != '0,
                        in_data.hund != '0, in_data.thou != '0};

    assign m_tvalid = out_valid_reg;
    assign m_code   = out_code_reg;
    assign m_last   = out_last_reg;

    always_comb begin
        busy_next      = busy_reg;
        rec_next       = rec_reg;
        mask_next      = mask_reg;
        pos_next       = pos_reg;
        sent_next      = sent_reg;
        out_valid_next = out_valid_reg;
        out_code_next  = out_code_reg;
        out_last_next  = out_last_reg;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        if (load) begin
            // A zero number has no letters and is dropped here.
            busy_next = (load_mask != 4'b0000);
            rec_next  = in_data;
            mask_next = load_mask;
            pos_next  = '0;
            sent_next = '0;
        end else if (emit) begin
            out_valid_next = 1'b1;
            out_code_next  = letter;
            out_last_next  = is_last;
            sent_next      = sent_reg + 1'b1;
            mask_next      = mask_after;
            if (is_last) begin
                busy_next = 1'b0;
            end
            if (place_done) begin
                pos_next = '0;
            end else if (place == renc_pkg::PL_THOU) begin
                rec_next.thou = rec_reg.thou - 1'b1;
            end else begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rec_reg      <= rec_next;
        mask_reg     <= mask_next;
        pos_reg      <= pos_next;
        sent_reg     <= sent_next;
        out_code_reg <= out_code_next;
        out_last_reg <= out_last_next;
    end

endmodule

`default_nettype wire
